@@ rtl/cau_pkg.sv @@
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = PW + 1;
    localparam int NW = PW + FRAC_BITS;

    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_CONJ = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [2:0]            op;
        logic [DATA_WIDTH-1:0] simp_re;
        logic [DATA_WIDTH-1:0] simp_im;
        logic                  simp_ovf;
        logic [DATA_WIDTH-1:0] mul_re;
        logic [DATA_WIDTH-1:0] mul_im;
        logic                  mul_ovf;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic                  pre_re;
        logic                  pre_im;
    } side_t;

    typedef struct packed {
        logic [PW-1:0]         rem;
        logic [DATA_WIDTH-1:0] low;
        logic [DATA_WIDTH-1:0] q;
    } div_lane_t;

endpackage

@@ rtl/complex_arithmetic_unit_core.sv @@
// Throughput: one transfer per clock cycle; busy is never raised and nothing stalls.
// The division is a restoring pipeline of DATA_WIDTH stages, one quotient bit per stage,
// and it sets the latency of every operation.
// Reset is asynchronous and active low; it clears the valid bits only.
// The receiver cannot stall: each result is shown for one cycle with done high.
module complex_arithmetic_unit_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           req_type,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] a_imag,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_real,
    input  logic signed [cau_pkg::DATA_WIDTH-1:0] b_imag,
    output logic                                 done,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] result_real,
    output logic signed [cau_pkg::DATA_WIDTH-1:0] result_imag,
    output logic [1:0]                           status
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;

    // Stage A: input registers.
    logic                 va_reg;
    logic [2:0]           op_a_reg;
    logic signed [DW-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    // Stage B: products and simple operations.
    logic                 vb_reg;
    logic [2:0]           op_b_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic [PW-1:0]        sq_r_reg, sq_i_reg;
    logic [DW-1:0]        simp_re_b_reg, simp_im_b_reg;
    logic                 simp_ovf_b_reg;

    // Stage C: sums of products and divisor.
    logic                 vc_reg;
    logic [2:0]           op_c_reg;
    logic signed [SW-1:0] mre_reg, mim_reg, dre_reg, dim_reg;
    logic [PW-1:0]        d_c_reg;
    logic [DW-1:0]        simp_re_c_reg, simp_im_c_reg;
    logic                 simp_ovf_c_reg;

    // Stage D: multiply scaling and dividend magnitudes.
    logic                 vd_reg;
    side_t                side_d_reg;
    logic [PW-1:0]        mag_re_reg, mag_im_reg;
    logic [PW-1:0]        d_d_reg;

    // Divider pipeline: index 0 is stage E, index k+1 the output of step k.
    logic                 dv_reg   [0:DW];
    side_t                dside_reg[0:DW];
    div_lane_t            lre_reg  [0:DW];
    div_lane_t            lim_reg  [0:DW];
    logic [PW-1:0]        dd_reg   [0:DW];

    // Output registers.
    logic                 done_reg;
    logic [DW-1:0]        res_re_reg, res_im_reg;
    logic [1:0]           status_reg;

    // Combinational signals.
    logic signed [DW:0]   add_re, add_im, sub_re, sub_im, neg_im;
    logic [DW-1:0]        simp_re_next, simp_im_next;
    logic                 simp_ovf_next;
    logic [PW-1:0]        abs_br, abs_bi;
    logic signed [SW-1:0] sh_re, sh_im;
    logic                 fit_re, fit_im;
    side_t                side_d_next;
    logic [NW-1:0]        n_re, n_im, hi_re, hi_im;
    side_t                side_e_next;
    logic [DW-1:0]        lim_val_re, lim_val_im, qv_re, qv_im;
    logic                 ovf_re, ovf_im;
    logic [DW-1:0]        div_re, div_im;
    logic [DW-1:0]        res_re_next, res_im_next;
    logic [1:0]           status_next;
    side_t                sf;

    assign busy = 1'b0;

    // Stage B logic.
    always_comb
    begin
        add_re = {ar_reg[DW-1], ar_reg} + {br_reg[DW-1], br_reg};
        add_im = {ai_reg[DW-1], ai_reg} + {bi_reg[DW-1], bi_reg};
        sub_re = {ar_reg[DW-1], ar_reg} - {br_reg[DW-1], br_reg};
        sub_im = {ai_reg[DW-1], ai_reg} - {bi_reg[DW-1], bi_reg};
        neg_im = {(DW+1){1'b0}} - {ai_reg[DW-1], ai_reg};
        simp_re_next  = ar_reg;
        simp_im_next  = ai_reg;
        simp_ovf_next = 1'b0;
        case (op_a_reg)
            OP_ADD:
            begin
                simp_re_next = (add_re[DW] != add_re[DW-1]) ?
                               (add_re[DW] ? MIN_NEG : MAX_POS) : add_re[DW-1:0];
                simp_im_next = (add_im[DW] != add_im[DW-1]) ?
                               (add_im[DW] ? MIN_NEG : MAX_POS) : add_im[DW-1:0];
                simp_ovf_next = (add_re[DW] != add_re[DW-1]) ||
                                (add_im[DW] != add_im[DW-1]);
            end
            OP_SUB:
            begin
                simp_re_next = (sub_re[DW] != sub_re[DW-1]) ?
                               (sub_re[DW] ? MIN_NEG : MAX_POS) : sub_re[DW-1:0];
                simp_im_next = (sub_im[DW] != sub_im[DW-1]) ?
                               (sub_im[DW] ? MIN_NEG : MAX_POS) : sub_im[DW-1:0];
                simp_ovf_next = (sub_re[DW] != sub_re[DW-1]) ||
                                (sub_im[DW] != sub_im[DW-1]);
            end
            default:
            begin
                simp_re_next  = ar_reg;
                simp_im_next  = (neg_im[DW] != neg_im[DW-1]) ? MAX_POS : neg_im[DW-1:0];
                simp_ovf_next = (neg_im[DW] != neg_im[DW-1]);
            end
        endcase
        abs_br = {{DW{1'b0}}, (br_reg[DW-1] ? -br_reg : br_reg)};
        abs_bi = {{DW{1'b0}}, (bi_reg[DW-1] ? -bi_reg : bi_reg)};
    end

    // Stage D logic.
    always_comb
    begin
        sh_re  = mre_reg >>> FRAC_BITS;
        sh_im  = mim_reg >>> FRAC_BITS;
        fit_re = (&sh_re[SW-1:DW-1]) || !(|sh_re[SW-1:DW-1]);
        fit_im = (&sh_im[SW-1:DW-1]) || !(|sh_im[SW-1:DW-1]);
        side_d_next          = '0;
        side_d_next.op       = op_c_reg;
        side_d_next.simp_re  = simp_re_c_reg;
        side_d_next.simp_im  = simp_im_c_reg;
        side_d_next.simp_ovf = simp_ovf_c_reg;
        side_d_next.mul_re   = fit_re ? sh_re[DW-1:0] : (mre_reg[SW-1] ? MIN_NEG : MAX_POS);
        side_d_next.mul_im   = fit_im ? sh_im[DW-1:0] : (mim_reg[SW-1] ? MIN_NEG : MAX_POS);
        side_d_next.mul_ovf  = !fit_re || !fit_im;
        side_d_next.dz       = (d_c_reg == '0);
        side_d_next.neg_re   = dre_reg[SW-1];
        side_d_next.neg_im   = dim_reg[SW-1];
    end

    // Stage E logic: scaled dividend and quotient overflow precheck.
    always_comb
    begin
        n_re  = NW'(mag_re_reg) << FRAC_BITS;
        n_im  = NW'(mag_im_reg) << FRAC_BITS;
        hi_re = n_re >> DW;
        hi_im = n_im >> DW;
        side_e_next        = side_d_reg;
        side_e_next.pre_re = (hi_re >= NW'(d_d_reg));
        side_e_next.pre_im = (hi_im >= NW'(d_d_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
            vc_reg    <= 1'b0;
            vd_reg    <= 1'b0;
            dv_reg[0] <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            va_reg    <= start && !busy;
            vb_reg    <= va_reg;
            vc_reg    <= vb_reg;
            vd_reg    <= vc_reg;
            dv_reg[0] <= vd_reg;
            done_reg  <= dv_reg[DW];
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg <= req_type;
        ar_reg   <= a_real;
        ai_reg   <= a_imag;
        br_reg   <= b_real;
        bi_reg   <= b_imag;

        op_b_reg       <= op_a_reg;
        p_rr_reg       <= PW'(ar_reg) * PW'(br_reg);
        p_ii_reg       <= PW'(ai_reg) * PW'(bi_reg);
        p_ri_reg       <= PW'(ar_reg) * PW'(bi_reg);
        p_ir_reg       <= PW'(ai_reg) * PW'(br_reg);
        sq_r_reg       <= abs_br * abs_br;
        sq_i_reg       <= abs_bi * abs_bi;
        simp_re_b_reg  <= simp_re_next;
        simp_im_b_reg  <= simp_im_next;
        simp_ovf_b_reg <= simp_ovf_next;

        op_c_reg       <= op_b_reg;
        mre_reg        <= SW'(p_rr_reg) - SW'(p_ii_reg);
        mim_reg        <= SW'(p_ri_reg) + SW'(p_ir_reg);
        dre_reg        <= SW'(p_rr_reg) + SW'(p_ii_reg);
        dim_reg        <= SW'(p_ir_reg) - SW'(p_ri_reg);
        d_c_reg        <= sq_r_reg + sq_i_reg;
        simp_re_c_reg  <= simp_re_b_reg;
        simp_im_c_reg  <= simp_im_b_reg;
        simp_ovf_c_reg <= simp_ovf_b_reg;

        side_d_reg <= side_d_next;
        mag_re_reg <= PW'(dre_reg[SW-1] ? -dre_reg : dre_reg);
        mag_im_reg <= PW'(dim_reg[SW-1] ? -dim_reg : dim_reg);
        d_d_reg    <= d_c_reg;

        dside_reg[0]   <= side_e_next;
        dd_reg[0]      <= d_d_reg;
        lre_reg[0].rem <= hi_re[PW-1:0];
        lre_reg[0].low <= n_re[DW-1:0];
        lre_reg[0].q   <= '0;
        lim_reg[0].rem <= hi_im[PW-1:0];
        lim_reg[0].low <= n_im[DW-1:0];
        lim_reg[0].q   <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < DW; k++)
        begin : g_div
            logic [PW:0] t_re, t_im, df_re, df_im;
            logic        ge_re, ge_im;

            always_comb
            begin
                t_re  = {lre_reg[k].rem, lre_reg[k].low[DW-1]};
                t_im  = {lim_reg[k].rem, lim_reg[k].low[DW-1]};
                ge_re = (t_re >= {1'b0, dd_reg[k]});
                ge_im = (t_im >= {1'b0, dd_reg[k]});
                df_re = t_re - {1'b0, dd_reg[k]};
                df_im = t_im - {1'b0, dd_reg[k]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[k+1] <= 1'b0;
                end
                else
                begin
                    dv_reg[k+1] <= dv_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                dside_reg[k+1]   <= dside_reg[k];
                dd_reg[k+1]      <= dd_reg[k];
                lre_reg[k+1].rem <= ge_re ? df_re[PW-1:0] : t_re[PW-1:0];
                lre_reg[k+1].low <= lre_reg[k].low << 1;
                lre_reg[k+1].q   <= {lre_reg[k].q[DW-2:0], ge_re};
                lim_reg[k+1].rem <= ge_im ? df_im[PW-1:0] : t_im[PW-1:0];
                lim_reg[k+1].low <= lim_reg[k].low << 1;
                lim_reg[k+1].q   <= {lim_reg[k].q[DW-2:0], ge_im};
            end
        end
    endgenerate

    // Final stage: sign, saturation and selection.
    always_comb
    begin
        sf         = dside_reg[DW];
        qv_re      = lre_reg[DW].q;
        qv_im      = lim_reg[DW].q;
        lim_val_re = MAX_POS + DW'(sf.neg_re);
        lim_val_im = MAX_POS + DW'(sf.neg_im);
        ovf_re     = sf.pre_re || (qv_re > lim_val_re);
        ovf_im     = sf.pre_im || (qv_im > lim_val_im);
        div_re     = ovf_re ? (sf.neg_re ? MIN_NEG : MAX_POS) : (sf.neg_re ? -qv_re : qv_re);
        div_im     = ovf_im ? (sf.neg_im ? MIN_NEG : MAX_POS) : (sf.neg_im ? -qv_im : qv_im);
        res_re_next = '0;
        res_im_next = '0;
        status_next = ST_OK;
        case (sf.op) inside
            OP_ADD, OP_SUB, OP_CONJ:
            begin
                res_re_next = sf.simp_re;
                res_im_next = sf.simp_im;
                status_next = sf.simp_ovf ? ST_SAT : ST_OK;
            end
            OP_MUL:
            begin
                res_re_next = sf.mul_re;
                res_im_next = sf.mul_im;
                status_next = sf.mul_ovf ? ST_SAT : ST_OK;
            end
            OP_DIV:
            begin
                if (sf.dz)
                begin
                    status_next = ST_DIV0;
                end
                else
                begin
                    res_re_next = div_re;
                    res_im_next = div_im;
                    status_next = (ovf_re || ovf_im) ? ST_SAT : ST_OK;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        status_reg <= status_next;
    end

    assign done        = done_reg;
    assign result_real = res_re_reg;
    assign result_imag = res_im_reg;
    assign status      = status_reg;

endmodule

@@ rtl/cau_checker.sv @@
module cau_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          busy,
    input logic                          done,
    input logic [cau_pkg::DATA_WIDTH-1:0] result_real,
    input logic [cau_pkg::DATA_WIDTH-1:0] result_imag,
    input logic [1:0]                    status
);
    import cau_pkg::*;

    // The unit takes a transfer in every cycle.
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_DIV0 || status == ST_SAT))
        else $error("status code out of range");

    a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DIV0) |-> (result_real == '0 && result_imag == '0))
        else $error("divide by zero result not zero");

    // A saturated result holds a limit value in at least one component.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_SAT) |->
        (result_real == MAX_POS || result_real == MIN_NEG ||
         result_imag == MAX_POS || result_imag == MIN_NEG))
        else $error("saturated status without a limit value");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .done        (done),
    .result_real (result_real),
    .result_imag (result_imag),
    .status      (status)
);

@@ sim/complex_arithmetic_unit_core_tb.sv @@
module complex_arithmetic_unit_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int DW        = DATA_WIDTH;
    localparam int N_RANDOM  = 750;
    localparam int LATENCY   = DW + 6;
    localparam int MAX_CYCLES = 200000;

    typedef struct packed {
        logic [2:0]    op;
        logic [DW-1:0] ar;
        logic [DW-1:0] ai;
        logic [DW-1:0] br;
        logic [DW-1:0] bi;
    } operands_t;

    typedef struct packed {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
        logic [1:0]    st;
    } answer_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    logic [2:0]    req_type;
    logic [DW-1:0] a_real;
    logic [DW-1:0] a_imag;
    logic [DW-1:0] b_real;
    logic [DW-1:0] b_imag;
    logic          done;
    logic [DW-1:0] result_real;
    logic [DW-1:0] result_imag;
    logic [1:0]    status;

    operands_t pending_ops[$];
    answer_t   expected_answers[$];
    int        errors;
    int        cycles;
    int        burst_left;
    int        gap_left;
    bit        drain_hold;
    bit        stimulus_done;

    complex_arithmetic_unit_core uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .a_real(a_real),
        .a_imag(a_imag),
        .b_real(b_real),
        .b_imag(b_imag),
        .done(done),
        .result_real(result_real),
        .result_imag(result_imag),
        .status(status)
    );

    function automatic logic signed [DW-1:0] clamp(input logic signed [191:0] v,
                                                   inout bit ovf);
        logic signed [191:0] hi;
        logic signed [191:0] lo;
        hi = (192'sd1 <<< (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    function automatic logic signed [191:0] quotient_toward_zero(input logic signed [191:0] num,
                                                                 input logic signed [191:0] den);
        logic signed [191:0] mag;
        logic signed [191:0] q;
        mag = (num < 0) ? -num : num;
        q = mag / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic answer_t complex_result(input operands_t x);
        logic signed [191:0] ar;
        logic signed [191:0] ai;
        logic signed [191:0] br;
        logic signed [191:0] bi;
        logic signed [191:0] den;
        answer_t r;
        bit ovf;
        ar = $signed(x.ar);
        ai = $signed(x.ai);
        br = $signed(x.br);
        bi = $signed(x.bi);
        ovf = 1'b0;
        r = '0;
        r.st = ST_OK;
        case (x.op)
            OP_ADD:
            begin
                r.re = clamp(ar + br, ovf);
                r.im = clamp(ai + bi, ovf);
            end
            OP_SUB:
            begin
                r.re = clamp(ar - br, ovf);
                r.im = clamp(ai - bi, ovf);
            end
            OP_MUL:
            begin
                r.re = clamp((ar * br - ai * bi) >>> FRAC_BITS, ovf);
                r.im = clamp((ar * bi + ai * br) >>> FRAC_BITS, ovf);
            end
            OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    r.st = ST_DIV0;
                else
                begin
                    r.re = clamp(quotient_toward_zero((ar * br + ai * bi) <<< FRAC_BITS, den),
                                 ovf);
                    r.im = clamp(quotient_toward_zero((ai * br - ar * bi) <<< FRAC_BITS, den),
                                 ovf);
                end
            end
            OP_CONJ:
            begin
                r.re = x.ar;
                r.im = clamp(-ai, ovf);
            end
            default:
            begin
            end
        endcase
        if (ovf)
            r.st = ST_SAT;
        return r;
    endfunction

    function automatic logic [DW-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return MAX_POS;
            1: return MIN_NEG;
            2: return '0;
            3: return DW'($signed($urandom_range(0, 8'hff) - 128) <<< FRAC_BITS);
            4, 5: return DW'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] op, input logic [DW-1:0] ar,
                              input logic [DW-1:0] ai, input logic [DW-1:0] br,
                              input logic [DW-1:0] bi);
        operands_t x;
        x.op = op;
        x.ar = ar;
        x.ai = ai;
        x.br = br;
        x.bi = bi;
        pending_ops.push_back(x);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        logic [2:0] op;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        drain_hold = 1'b0;
        queue_item(OP_ADD, MAX_POS, MIN_NEG, MAX_POS, MIN_NEG);
        queue_item(OP_ADD, 32'h0001_8000, 32'hffff_0000, 32'h0002_0000, 32'h0000_4000);
        queue_item(OP_SUB, MIN_NEG, MAX_POS, MAX_POS, MIN_NEG);
        queue_item(OP_SUB, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0004_0000);
        queue_item(OP_MUL, MAX_POS, MAX_POS, MAX_POS, MIN_NEG);
        queue_item(OP_MUL, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG);
        queue_item(OP_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
        queue_item(OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hffff_0000);
        queue_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, '0, '0);
        queue_item(OP_DIV, MAX_POS, MIN_NEG, 32'h0000_0001, '0);
        queue_item(OP_DIV, MIN_NEG, MIN_NEG, MIN_NEG, MIN_NEG);
        queue_item(OP_DIV, 32'hffff_0000, 32'h0001_0000, 32'h0003_0000, '0);
        queue_item(OP_DIV, 32'h0001_0000, '0, 32'h0003_0000, 32'h0004_0000);
        queue_item(OP_DIV, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
        queue_item(OP_CONJ, MIN_NEG, MIN_NEG, MAX_POS, MAX_POS);
        queue_item(OP_CONJ, MAX_POS, MAX_POS, '0, '0);
        queue_item(3'd5, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
        queue_item(3'd6, MIN_NEG, 32'h1234_5678, '0, '0);
        queue_item(3'd7, '1, '1, '1, '1);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
            queue_item(op, random_value(), random_value(),
                       ($urandom_range(0, 15) == 0) ? '0 : random_value(),
                       ($urandom_range(0, 15) == 0) ? '0 : random_value());
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_ops.size() < N_RANDOM / 2);
        @(negedge clk);
        drain_hold = 1'b1;
        wait (expected_answers.size() == 0);
        @(negedge clk);
        drain_hold = 1'b0;
        wait (pending_ops.size() == 0);
        stimulus_done = 1'b1;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= '0;
            a_real <= '0;
            a_imag <= '0;
            b_real <= '0;
            b_imag <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_ops.size() > 0 && !drain_hold)
        begin
            operands_t x;
            x = pending_ops.pop_front();
            start <= 1'b1;
            req_type <= x.op;
            a_real <= x.ar;
            a_imag <= x.ai;
            b_real <= x.br;
            b_imag <= x.bi;
            if (burst_left > 0)
                burst_left <= burst_left - 1;
            else
            begin
                burst_left <= $urandom_range(0, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                operands_t x;
                x.op = req_type;
                x.ar = a_real;
                x.ai = a_imag;
                x.br = b_real;
                x.bi = b_imag;
                expected_answers.push_back(complex_result(x));
            end
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (result_real !== e.re)
                    begin
                        $error("result_real expected %h actual %h", e.re, result_real);
                        errors++;
                    end
                    if (result_imag !== e.im)
                    begin
                        $error("result_imag expected %h actual %h", e.im, result_imag);
                        errors++;
                    end
                    if (status !== e.st)
                    begin
                        $error("status expected %0d actual %0d", e.st, status);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        fork
            begin
                wait (stimulus_done);
                @(negedge clk);
                wait (expected_answers.size() == 0);
                repeat (LATENCY + 10) @(posedge clk);
            end
            begin
                while (cycles < MAX_CYCLES)
                begin
                    @(posedge clk);
                    cycles++;
                end
                errors++;
                $display("timeout after %0d cycles", cycles);
            end
        join_any
        if (errors == 0)
            $display("complex_arithmetic_unit_core verification clean");
        else
            $display("complex_arithmetic_unit_core verification failed");
        $finish;
    end

endmodule
